// ----- design/sst_pkg.sv -----
// Shared types and constants for the SIP server transaction block.
package sst_pkg;

	typedef enum logic [1:0] {
		REQ_START    = 2'd0,
		REQ_RECEIVED = 2'd1,
		REQ_RESPONSE = 2'd2,
		REQ_TICK     = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ACT_NONE        = 2'd0,
		ACT_SEND_STORED = 2'd1,
		ACT_SEND_TRYING = 2'd2
	} send_action_t;

	typedef enum logic [2:0] {
		PH_TRYING     = 3'd0,
		PH_PROCEEDING = 3'd1,
		PH_CALLING    = 3'd2,
		PH_COMPLETED  = 3'd3,
		PH_CONFIRMED  = 3'd4,
		PH_TERMINATED = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CFG_T1        = 2'd0,
		CFG_T2        = 2'd1,
		CFG_T4        = 2'd2,
		CFG_PROV_DLY  = 2'd3
	} cfg_index_t;

	localparam logic [15:0] T1_RESET       = 16'd500;
	localparam logic [15:0] T2_RESET       = 16'd4000;
	localparam logic [15:0] T4_RESET       = 16'd5000;
	localparam logic [15:0] PROV_DLY_RESET = 16'd200;

	localparam logic [9:0] CODE_CLASS1_LO = 10'd100;
	localparam logic [9:0] CODE_CLASS2_LO = 10'd200;
	localparam logic [9:0] CODE_CLASS3_LO = 10'd300;

	localparam int TIMEOUT_SHIFT = 6;
	localparam logic [4:0] RETRY_MAX = 5'd31;

	typedef struct packed {
		logic [15:0] t1_ticks;
		logic [15:0] t2_ticks;
		logic [15:0] t4_ticks;
		logic [15:0] provisional_delay;
	} cfg_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic        method_invite;
		logic        transport_udp;
		logic        request_is_ack;
		logic [9:0]  status_code;
	} item_t;

	typedef struct packed {
		send_action_t send_action;
		logic         timed_out;
		logic         terminated;
		phase_t       txn_state;
	} result_t;

endpackage

// ----- design/sst_cfg_regs.sv -----
// Configuration register file for the SIP server transaction block.
module sst_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_addr,
	input  logic [15:0]        cfg_data,
	output sst_pkg::cfg_t      cfg
);
	import sst_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.t1_ticks          <= T1_RESET;
			cfg_q.t2_ticks          <= T2_RESET;
			cfg_q.t4_ticks          <= T4_RESET;
			cfg_q.provisional_delay <= PROV_DLY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_addr))
				CFG_T1:       cfg_q.t1_ticks          <= cfg_data;
				CFG_T2:       cfg_q.t2_ticks          <= cfg_data;
				CFG_T4:       cfg_q.t4_ticks          <= cfg_data;
				CFG_PROV_DLY: cfg_q.provisional_delay <= cfg_data;
				default:      ;
			endcase
		end
	end

endmodule

// ----- design/sst_txn.sv -----
// Transaction state, timers and per-item next-state and result logic.
module sst_txn #(
	parameter int TIMER_BITS  = 24,
	parameter int HANDLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  sst_pkg::item_t         item,
	input  logic [HANDLE_BITS-1:0] item_handle,
	input  sst_pkg::cfg_t          cfg,
	output sst_pkg::result_t       res,
	output logic [HANDLE_BITS-1:0] res_handle
);
	import sst_pkg::*;

	localparam int T64_BITS = 16 + TIMEOUT_SHIFT;
	localparam int EXT_BITS = (TIMER_BITS > T64_BITS) ? TIMER_BITS : T64_BITS;

	phase_t                 phase_q, phase_n;
	logic                   invite_q, invite_n;
	logic                   udp_q, udp_n;
	logic                   have_rsp_q, have_rsp_n;
	logic                   rsp_gen_q, rsp_gen_n;
	logic [HANDLE_BITS-1:0] handle_q, handle_n;
	logic [4:0]             retry_cnt_q, retry_cnt_n;
	logic [TIMER_BITS-1:0]  retry_tmr_q, retry_tmr_n;
	logic [TIMER_BITS-1:0]  tmo_tmr_q, tmo_tmr_n;
	logic [TIMER_BITS-1:0]  linger_tmr_q, linger_tmr_n;
	logic [15:0]            prov_tmr_q, prov_tmr_n;
	logic                   act_retry_q, act_retry_n;
	logic                   act_tmo_q, act_tmo_n;
	logic                   act_linger_q, act_linger_n;
	logic                   act_prov_q, act_prov_n;

	logic [4:0]            retry_cnt_inc;
	logic [31:0]           retry_shift;
	logic [TIMER_BITS-1:0] retry_dly;
	logic [TIMER_BITS-1:0] tmo_dly;
	logic [TIMER_BITS-1:0] linger_dly;
	logic [EXT_BITS-1:0]   t1x64_ext;
	logic                  cls1, cls2;
	logic                  f_retry, f_tmo, f_linger, f_prov;
	send_action_t          action;
	logic                  tmo, term;

	assign retry_cnt_inc = (retry_cnt_q == RETRY_MAX) ? RETRY_MAX : retry_cnt_q + 5'd1;
	assign retry_shift   = {16'd0, cfg.t1_ticks} << retry_cnt_inc[3:0];
	assign retry_dly     = ((retry_cnt_inc[4] && cfg.t1_ticks != 16'd0) ||
	                        retry_shift > {16'd0, cfg.t2_ticks})
	                       ? TIMER_BITS'(cfg.t2_ticks) : TIMER_BITS'(retry_shift[15:0]);

	assign t1x64_ext = EXT_BITS'({cfg.t1_ticks, {TIMEOUT_SHIFT{1'b0}}});
	assign tmo_dly   = ((t1x64_ext >> TIMER_BITS) != '0) ? {TIMER_BITS{1'b1}}
	                                                      : TIMER_BITS'(t1x64_ext);
	assign linger_dly = invite_q ? TIMER_BITS'(cfg.t4_ticks) : tmo_dly;

	assign cls1 = item.status_code >= CODE_CLASS1_LO && item.status_code < CODE_CLASS2_LO;
	assign cls2 = item.status_code >= CODE_CLASS2_LO && item.status_code < CODE_CLASS3_LO;

	assign f_retry  = act_retry_q  && retry_tmr_q  <= TIMER_BITS'(1);
	assign f_tmo    = act_tmo_q    && tmo_tmr_q    <= TIMER_BITS'(1);
	assign f_linger = act_linger_q && linger_tmr_q <= TIMER_BITS'(1);
	assign f_prov   = act_prov_q   && prov_tmr_q   <= 16'd1;

	always_comb begin
		phase_n      = phase_q;
		invite_n     = invite_q;
		udp_n        = udp_q;
		have_rsp_n   = have_rsp_q;
		rsp_gen_n    = rsp_gen_q;
		handle_n     = handle_q;
		retry_cnt_n  = retry_cnt_q;
		retry_tmr_n  = retry_tmr_q;
		tmo_tmr_n    = tmo_tmr_q;
		linger_tmr_n = linger_tmr_q;
		prov_tmr_n   = prov_tmr_q;
		act_retry_n  = act_retry_q;
		act_tmo_n    = act_tmo_q;
		act_linger_n = act_linger_q;
		act_prov_n   = act_prov_q;
		action       = ACT_NONE;
		tmo          = 1'b0;
		term         = 1'b0;

		if (item.req_type == REQ_START) begin
			invite_n     = item.method_invite;
			udp_n        = item.transport_udp;
			have_rsp_n   = 1'b0;
			rsp_gen_n    = 1'b0;
			handle_n     = '0;
			retry_cnt_n  = '0;
			retry_tmr_n  = '0;
			tmo_tmr_n    = '0;
			linger_tmr_n = '0;
			act_retry_n  = 1'b0;
			act_tmo_n    = 1'b0;
			act_linger_n = 1'b0;
			if (item.method_invite) begin
				phase_n    = PH_CALLING;
				prov_tmr_n = cfg.provisional_delay;
				act_prov_n = 1'b1;
			end else begin
				phase_n    = PH_TRYING;
				prov_tmr_n = '0;
				act_prov_n = 1'b0;
			end
		end else if (phase_q == PH_TERMINATED) begin
			phase_n = phase_q;
		end else if (item.req_type == REQ_RECEIVED) begin
			if (!item.request_is_ack && have_rsp_q &&
			    (phase_q == PH_PROCEEDING || phase_q == PH_CALLING ||
			     phase_q == PH_COMPLETED))
				action = rsp_gen_q ? ACT_SEND_TRYING : ACT_SEND_STORED;
			if (phase_q == PH_COMPLETED && item.request_is_ack) begin
				retry_tmr_n = '0;
				tmo_tmr_n   = '0;
				prov_tmr_n  = '0;
				act_retry_n = 1'b0;
				act_tmo_n   = 1'b0;
				act_prov_n  = 1'b0;
				if (!udp_q) begin
					phase_n      = PH_TERMINATED;
					linger_tmr_n = '0;
					act_linger_n = 1'b0;
					term         = 1'b1;
				end else begin
					phase_n      = PH_CONFIRMED;
					linger_tmr_n = linger_dly;
					act_linger_n = 1'b1;
				end
			end
		end else if (item.req_type == REQ_RESPONSE) begin
			if (phase_q == PH_TRYING || phase_q == PH_PROCEEDING ||
			    phase_q == PH_CALLING) begin
				if (phase_q == PH_CALLING) begin
					act_prov_n = 1'b0;
					prov_tmr_n = '0;
				end
				have_rsp_n = 1'b1;
				rsp_gen_n  = 1'b0;
				handle_n   = item_handle;
				action     = ACT_SEND_STORED;
				if (cls1) begin
					if (phase_q == PH_TRYING)
						phase_n = PH_PROCEEDING;
				end else if (cls2 && phase_q == PH_CALLING) begin
					phase_n = PH_TERMINATED;
				end else begin
					phase_n = PH_COMPLETED;
					if (invite_q) begin
						if (udp_q) begin
							retry_cnt_n = retry_cnt_inc;
							retry_tmr_n = retry_dly;
							act_retry_n = 1'b1;
						end
						tmo_tmr_n = tmo_dly;
						act_tmo_n = 1'b1;
					end else if (!udp_q) begin
						phase_n = PH_TERMINATED;
					end else begin
						linger_tmr_n = linger_dly;
						act_linger_n = 1'b1;
					end
				end
				if (phase_n == PH_TERMINATED) begin
					retry_tmr_n  = '0;
					tmo_tmr_n    = '0;
					linger_tmr_n = '0;
					prov_tmr_n   = '0;
					act_retry_n  = 1'b0;
					act_tmo_n    = 1'b0;
					act_linger_n = 1'b0;
					act_prov_n   = 1'b0;
					term         = 1'b1;
				end
			end
		end else begin
			if (act_retry_q)
				retry_tmr_n = f_retry ? '0 : retry_tmr_q - TIMER_BITS'(1);
			if (act_tmo_q)
				tmo_tmr_n = f_tmo ? '0 : tmo_tmr_q - TIMER_BITS'(1);
			if (act_linger_q)
				linger_tmr_n = f_linger ? '0 : linger_tmr_q - TIMER_BITS'(1);
			if (act_prov_q)
				prov_tmr_n = f_prov ? '0 : prov_tmr_q - 16'd1;
			if (f_retry)  act_retry_n  = 1'b0;
			if (f_tmo)    act_tmo_n    = 1'b0;
			if (f_linger) act_linger_n = 1'b0;
			if (f_prov)   act_prov_n   = 1'b0;

			if (f_tmo || f_linger) begin
				tmo          = f_tmo;
				phase_n      = PH_TERMINATED;
				retry_tmr_n  = '0;
				tmo_tmr_n    = '0;
				linger_tmr_n = '0;
				prov_tmr_n   = '0;
				act_retry_n  = 1'b0;
				act_tmo_n    = 1'b0;
				act_linger_n = 1'b0;
				act_prov_n   = 1'b0;
				term         = 1'b1;
			end else begin
				if (f_retry && have_rsp_q) begin
					action      = rsp_gen_q ? ACT_SEND_TRYING : ACT_SEND_STORED;
					retry_cnt_n = retry_cnt_inc;
					retry_tmr_n = retry_dly;
					act_retry_n = 1'b1;
				end
				if (f_prov) begin
					if (have_rsp_q && !rsp_gen_q) begin
						action = ACT_SEND_STORED;
					end else begin
						have_rsp_n = 1'b1;
						rsp_gen_n  = 1'b1;
						action     = ACT_SEND_TRYING;
					end
				end
			end
		end
	end

	assign res.send_action = action;
	assign res.timed_out   = tmo;
	assign res.terminated  = term;
	assign res.txn_state   = phase_n;
	assign res_handle      = (action == ACT_SEND_STORED) ? handle_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TERMINATED;
			invite_q     <= 1'b0;
			udp_q        <= 1'b0;
			have_rsp_q   <= 1'b0;
			rsp_gen_q    <= 1'b0;
			handle_q     <= '0;
			retry_cnt_q  <= '0;
			retry_tmr_q  <= '0;
			tmo_tmr_q    <= '0;
			linger_tmr_q <= '0;
			prov_tmr_q   <= '0;
			act_retry_q  <= 1'b0;
			act_tmo_q    <= 1'b0;
			act_linger_q <= 1'b0;
			act_prov_q   <= 1'b0;
		end else if (en) begin
			phase_q      <= phase_n;
			invite_q     <= invite_n;
			udp_q        <= udp_n;
			have_rsp_q   <= have_rsp_n;
			rsp_gen_q    <= rsp_gen_n;
			handle_q     <= handle_n;
			retry_cnt_q  <= retry_cnt_n;
			retry_tmr_q  <= retry_tmr_n;
			tmo_tmr_q    <= tmo_tmr_n;
			linger_tmr_q <= linger_tmr_n;
			prov_tmr_q   <= prov_tmr_n;
			act_retry_q  <= act_retry_n;
			act_tmo_q    <= act_tmo_n;
			act_linger_q <= act_linger_n;
			act_prov_q   <= act_prov_n;
		end
	end

	a_idle_no_timers: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TERMINATED |->
			!act_retry_q && !act_tmo_q && !act_linger_q && !act_prov_q)
		else $error("timer running in terminated phase");

	a_term_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.terminated |=> phase_q == PH_TERMINATED)
		else $error("terminated result without terminated phase");

	a_timeout_ends: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.timed_out |-> res.terminated && res.send_action == ACT_NONE)
		else $error("timeout without termination");

	a_handle_gated: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.send_action != ACT_SEND_STORED |-> res_handle == '0)
		else $error("handle driven without stored response send");

endmodule

// ----- design/sip_server_transaction_fsm_core.sv -----
// Top level of the SIP server transaction block: stream ports and pipeline registers.
//
// Items enter on the s_axis channel: tuser carries the item kind (start, request
// received, response from user, tick), tdata carries the method, transport, ACK
// flag, status code and message handle. Every item yields one result on the
// m_axis channel: tuser carries the send action, tdata the handle to send, the
// timeout and termination flags and the transaction state after the item.
// Timer values are configured on the cfg channel, one 16-bit register per transfer.
// Write them only while no item is in flight; the block does not enforce this.
//
// An accepted item is held in an input register and processed once the output
// register can take its result, which is written there and drives m_axis_tvalid.
// One item per cycle is sustained while the receiver accepts every result: the
// next-state and timer update is a single pass of logic between the two registers.
// When the receiver stalls, the result holds in the output register; an empty input
// register still takes one more item before s_axis_tready drops.
// Reset leaves the transaction terminated, all timers stopped and the registers
// at T1 500, T2 4000, T4 5000 and provisional delay 200.
module sip_server_transaction_fsm_core #(
	parameter int TIMER_BITS  = 24,
	parameter int HANDLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// method_invite, transport_udp, request_is_ack, status_code[9:0], message_handle
	input  logic [((13 + HANDLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// req_type[1:0]
	input  logic [1:0]                            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// send_handle, timed_out, terminated, txn_state[2:0]
	output logic [((5 + HANDLE_BITS + 7) / 8) * 8 - 1:0]  m_axis_tdata,
	// send_action[1:0]
	output logic [1:0]                            m_axis_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_addr,
	input  logic [15:0]                           cfg_data
);
	import sst_pkg::*;

	localparam int OUT_W = ((5 + HANDLE_BITS + 7) / 8) * 8;

	cfg_t                   cfg;
	logic                   valid_s1;
	item_t                  item_s1;
	logic [HANDLE_BITS-1:0] handle_s1;
	logic                   out_valid_q;
	result_t                out_res_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	result_t                res;
	logic [HANDLE_BITS-1:0] res_handle;
	logic                   advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	sst_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sst_txn #(
		.TIMER_BITS  (TIMER_BITS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_txn (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.item        (item_s1),
		.item_handle (handle_s1),
		.cfg         (cfg),
		.res         (res),
		.res_handle  (res_handle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.req_type       <= req_kind_t'(s_axis_tuser);
			item_s1.method_invite  <= s_axis_tdata[0];
			item_s1.transport_udp  <= s_axis_tdata[1];
			item_s1.request_is_ack <= s_axis_tdata[2];
			item_s1.status_code    <= s_axis_tdata[12:3];
			handle_s1              <= s_axis_tdata[13 +: HANDLE_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_res_q    <= res;
			out_handle_q <= res_handle;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.send_action;
	assign m_axis_tdata  = OUT_W'({out_res_q.txn_state, out_res_q.terminated,
	                               out_res_q.timed_out, out_handle_q});

endmodule

// ----- tb/sst_txn_checker.sv -----
// Checker for the SIP server transaction block: watches all channels, predicts and compares.
`timescale 1ns / 100ps

module sst_txn_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// method_invite, transport_udp, request_is_ack, status_code[9:0], message_handle[15:0]
	input  logic [31:0] s_axis_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// send_handle[15:0], timed_out, terminated, txn_state[2:0]
	input  logic [23:0] m_axis_tdata,
	// send_action[1:0]
	input  logic [1:0]  m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import sst_pkg::*;

	typedef struct {
		send_action_t action;
		logic [15:0]  handle;
		logic         timed_out;
		logic         terminated;
		phase_t       state;
	} reply_t;

	localparam logic [23:0] TMR_MAX = '1;

	cfg_t        regs;
	phase_t      ph;
	logic        inv;
	logic        udp;
	logic        have_rsp;
	logic        rsp_gen;
	logic [15:0] stored;
	logic [4:0]  retries;
	logic [23:0] retry_tmr;
	logic [23:0] tmo_tmr;
	logic [23:0] linger_tmr;
	logic [15:0] prov_tmr;
	logic        run_retry;
	logic        run_tmo;
	logic        run_linger;
	logic        run_prov;
	reply_t      due_replies[$];
	int          errors = 0;

	function automatic logic [23:0] clamp_tmr(input logic [63:0] v);
		return (v > 64'(TMR_MAX)) ? TMR_MAX : v[23:0];
	endfunction

	function automatic void stop_timers();
		run_retry = 1'b0;
		run_tmo = 1'b0;
		run_linger = 1'b0;
		run_prov = 1'b0;
		retry_tmr = '0;
		tmo_tmr = '0;
		linger_tmr = '0;
		prov_tmr = '0;
	endfunction

	function automatic void reset_txn();
		regs.t1_ticks = T1_RESET;
		regs.t2_ticks = T2_RESET;
		regs.t4_ticks = T4_RESET;
		regs.provisional_delay = PROV_DLY_RESET;
		ph = PH_TERMINATED;
		inv = 1'b0;
		udp = 1'b0;
		have_rsp = 1'b0;
		rsp_gen = 1'b0;
		stored = '0;
		retries = '0;
		stop_timers();
	endfunction

	function automatic void arm_retry();
		logic [63:0] d;
		if (retries < RETRY_MAX)
			retries = retries + 1'b1;
		d = 64'(regs.t1_ticks) << retries;
		if (d > 64'(regs.t2_ticks))
			d = 64'(regs.t2_ticks);
		retry_tmr = clamp_tmr(d);
		run_retry = 1'b1;
	endfunction

	function automatic void arm_linger();
		logic [63:0] d;
		if (inv)
			d = 64'(regs.t4_ticks);
		else
			d = 64'(regs.t1_ticks) << TIMEOUT_SHIFT;
		linger_tmr = clamp_tmr(d);
		run_linger = 1'b1;
	endfunction

	function automatic reply_t advance_txn(input req_kind_t kind, input logic [31:0] data);
		reply_t      r;
		logic        ack;
		logic [9:0]  code;
		logic        is_prov;
		logic        is_ok;
		phase_t      old;
		logic        f_retry;
		logic        f_tmo;
		logic        f_linger;
		logic        f_prov;
		r.action = ACT_NONE;
		r.handle = '0;
		r.timed_out = 1'b0;
		r.terminated = 1'b0;
		f_retry = 1'b0;
		f_tmo = 1'b0;
		f_linger = 1'b0;
		f_prov = 1'b0;
		ack = data[2];
		code = data[12:3];
		is_prov = (code >= CODE_CLASS1_LO) && (code < CODE_CLASS2_LO);
		is_ok = (code >= CODE_CLASS2_LO) && (code < CODE_CLASS3_LO);
		if (kind == REQ_START) begin
			inv = data[0];
			udp = data[1];
			have_rsp = 1'b0;
			rsp_gen = 1'b0;
			stored = '0;
			retries = '0;
			stop_timers();
			if (inv) begin
				ph = PH_CALLING;
				prov_tmr = regs.provisional_delay;
				run_prov = 1'b1;
			end else begin
				ph = PH_TRYING;
			end
		end else if (ph == PH_TERMINATED) begin
			// idle: no effect
		end else if (kind == REQ_RECEIVED) begin
			if (!ack && have_rsp &&
			    (ph == PH_PROCEEDING || ph == PH_CALLING || ph == PH_COMPLETED))
				r.action = rsp_gen ? ACT_SEND_TRYING : ACT_SEND_STORED;
			if (ph == PH_COMPLETED && ack) begin
				ph = PH_CONFIRMED;
				stop_timers();
				if (!udp) begin
					ph = PH_TERMINATED;
					r.terminated = 1'b1;
				end else begin
					arm_linger();
				end
			end
		end else if (kind == REQ_RESPONSE) begin
			if (ph <= PH_CALLING) begin
				old = ph;
				if (ph == PH_CALLING) begin
					run_prov = 1'b0;
					prov_tmr = '0;
				end
				have_rsp = 1'b1;
				rsp_gen = 1'b0;
				stored = data[28:13];
				r.action = ACT_SEND_STORED;
				if (is_prov) begin
					if (old == PH_TRYING)
						ph = PH_PROCEEDING;
				end else if (is_ok && old == PH_CALLING) begin
					ph = PH_TERMINATED;
				end else begin
					ph = PH_COMPLETED;
				end
				if (ph == PH_COMPLETED) begin
					if (inv) begin
						if (udp)
							arm_retry();
						tmo_tmr = clamp_tmr(64'(regs.t1_ticks) << TIMEOUT_SHIFT);
						run_tmo = 1'b1;
					end else if (!udp) begin
						ph = PH_TERMINATED;
					end else begin
						arm_linger();
					end
				end
				if (ph == PH_TERMINATED) begin
					stop_timers();
					r.terminated = 1'b1;
				end
			end
		end else begin
			if (run_retry) begin
				f_retry = (retry_tmr <= 24'd1);
				retry_tmr = f_retry ? '0 : retry_tmr - 1'b1;
			end
			if (run_tmo) begin
				f_tmo = (tmo_tmr <= 24'd1);
				tmo_tmr = f_tmo ? '0 : tmo_tmr - 1'b1;
			end
			if (run_linger) begin
				f_linger = (linger_tmr <= 24'd1);
				linger_tmr = f_linger ? '0 : linger_tmr - 1'b1;
			end
			if (run_prov) begin
				f_prov = (prov_tmr <= 16'd1);
				prov_tmr = f_prov ? '0 : prov_tmr - 1'b1;
			end
			if (f_retry)
				run_retry = 1'b0;
			if (f_tmo)
				run_tmo = 1'b0;
			if (f_linger)
				run_linger = 1'b0;
			if (f_prov)
				run_prov = 1'b0;
			if (f_tmo || f_linger) begin
				r.timed_out = f_tmo;
				ph = PH_TERMINATED;
				stop_timers();
				r.terminated = 1'b1;
			end else begin
				if (f_retry && have_rsp) begin
					r.action = rsp_gen ? ACT_SEND_TRYING : ACT_SEND_STORED;
					arm_retry();
				end
				if (f_prov) begin
					if (have_rsp && !rsp_gen) begin
						r.action = ACT_SEND_STORED;
					end else begin
						have_rsp = 1'b1;
						rsp_gen = 1'b1;
						r.action = ACT_SEND_TRYING;
					end
				end
			end
		end
		r.state = ph;
		if (r.action == ACT_SEND_STORED)
			r.handle = stored;
		return r;
	endfunction

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			reset_txn();
			due_replies.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					CFG_T1:       regs.t1_ticks = cfg_data;
					CFG_T2:       regs.t2_ticks = cfg_data;
					CFG_T4:       regs.t4_ticks = cfg_data;
					CFG_PROV_DLY: regs.provisional_delay = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				due_replies.push_back(advance_txn(req_kind_t'(s_axis_tuser), s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.action = send_action_t'(m_axis_tuser);
				got.handle = m_axis_tdata[15:0];
				got.timed_out = m_axis_tdata[16];
				got.terminated = m_axis_tdata[17];
				got.state = phase_t'(m_axis_tdata[20:18]);
				if (due_replies.size() == 0) begin
					$error("unexpected result transfer: tuser %0d tdata %h",
					       m_axis_tuser, m_axis_tdata);
					errors++;
				end else begin
					want = due_replies.pop_front();
					if (got.action !== want.action) begin
						$error("send_action: expected %0d, actual %0d", want.action, got.action);
						errors++;
					end
					if (got.handle !== want.handle) begin
						$error("send_handle: expected %h, actual %h", want.handle, got.handle);
						errors++;
					end
					if (got.timed_out !== want.timed_out) begin
						$error("timed_out: expected %0d, actual %0d",
						       want.timed_out, got.timed_out);
						errors++;
					end
					if (got.terminated !== want.terminated) begin
						$error("terminated: expected %0d, actual %0d",
						       want.terminated, got.terminated);
						errors++;
					end
					if (got.state !== want.state) begin
						$error("txn_state: expected %0d, actual %0d", want.state, got.state);
						errors++;
					end
				end
			end
		end
		fail_count <= errors;
		pending <= due_replies.size();
	end

endmodule

// ----- tb/sip_server_transaction_fsm_core_tb.sv -----
// Top of the SIP server transaction testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sip_server_transaction_fsm_core_tb;
	import sst_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = REQ_TICK;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_addr = CFG_T1;
	logic [15:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          items_sent = 0;

	always #6 clk = ~clk;

	sip_server_transaction_fsm_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	sst_txn_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [31:0] item_word(input logic inv, input logic udp,
	                                          input logic ack, input logic [9:0] code,
	                                          input logic [15:0] hdl);
		return {3'b000, hdl, code, ack, udp, inv};
	endfunction

	function automatic logic [9:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return 10'($urandom_range(100, 199));
		else if (r < 50)
			return 10'($urandom_range(200, 299));
		else if (r < 90)
			return 10'($urandom_range(300, 699));
		return 10'($urandom_range(1023));
	endfunction

	task automatic send_item(input req_kind_t kind, input logic [31:0] data);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_timers(input logic [15:0] t1, input logic [15:0] t2,
	                           input logic [15:0] t4, input logic [15:0] prov);
		write_reg(CFG_T1, t1);
		write_reg(CFG_T2, t2);
		write_reg(CFG_T4, t4);
		write_reg(CFG_PROV_DLY, prov);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid, then hold until every result has drained
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic random_txn(input int len, input int tick_pct);
		int        r;
		req_kind_t kind;
		send_item(REQ_START, item_word(1'($urandom_range(1)), 1'($urandom_range(1)),
		                               1'($urandom_range(1)),
		                               10'($urandom_range(1023)), 16'($urandom)));
		repeat (len) begin
			r = $urandom_range(99);
			if (r < 2)
				kind = REQ_START;
			else if (r < tick_pct)
				kind = REQ_TICK;
			else if (r < tick_pct + (100 - tick_pct) / 2)
				kind = REQ_RESPONSE;
			else
				kind = REQ_RECEIVED;
			send_item(kind, item_word(1'($urandom_range(1)), 1'($urandom_range(1)),
			                          1'($urandom_range(1)), pick_code(), 16'($urandom)));
		end
	endtask

	task automatic run_phase(input int n_items, input int gap, input int stall);
		int goal;
		gap_pct = gap;
		stall_pct = stall;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			if ($urandom_range(5) == 0)
				random_txn($urandom_range(150, 350), 90);
			else
				random_txn($urandom_range(2, 40), 55);
		end
		drain();
	endtask

	task automatic directed_items();
		send_item(REQ_TICK, item_word(1'b1, 1'b1, 1'b1, 10'd1023, 16'hFFFF));
		send_item(REQ_RECEIVED, item_word(1'b0, 1'b0, 1'b1, 10'd0, 16'h0000));
		send_item(REQ_RESPONSE, item_word(1'b1, 1'b1, 1'b0, 10'd0, 16'hFFFF));
		send_item(REQ_START, item_word(1'b1, 1'b1, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_TICK, item_word(1'b0, 1'b0, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_RECEIVED, item_word(1'b0, 1'b0, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_RESPONSE, item_word(1'b0, 1'b0, 1'b0, 10'd180, 16'hFFFF));
		send_item(REQ_RESPONSE, item_word(1'b0, 1'b0, 1'b0, 10'd486, 16'h1234));
		send_item(REQ_RECEIVED, item_word(1'b0, 1'b0, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_TICK, item_word(1'b0, 1'b0, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_RESPONSE, item_word(1'b0, 1'b0, 1'b0, 10'd200, 16'hABCD));
		send_item(REQ_RECEIVED, item_word(1'b0, 1'b0, 1'b1, 10'd0, 16'h0000));
		send_item(REQ_TICK, item_word(1'b0, 1'b0, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_START, item_word(1'b0, 1'b0, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_RESPONSE, item_word(1'b0, 1'b0, 1'b0, 10'd1023, 16'h0000));
		send_item(REQ_START, item_word(1'b0, 1'b1, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_RESPONSE, item_word(1'b0, 1'b0, 1'b0, 10'd100, 16'h00FF));
		send_item(REQ_RECEIVED, item_word(1'b0, 1'b0, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_RESPONSE, item_word(1'b0, 1'b0, 1'b0, 10'd99, 16'h5A5A));
		send_item(REQ_RESPONSE, item_word(1'b0, 1'b0, 1'b0, 10'd300, 16'hA5A5));
		send_item(REQ_START, item_word(1'b1, 1'b0, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_RESPONSE, item_word(1'b0, 1'b0, 1'b0, 10'd200, 16'h7777));
		send_item(REQ_START, item_word(1'b1, 1'b1, 1'b0, 10'd0, 16'h0000));
		send_item(REQ_RESPONSE, item_word(1'b0, 1'b0, 1'b0, 10'd700, 16'h8001));
		send_item(REQ_RECEIVED, item_word(1'b0, 1'b0, 1'b1, 10'd0, 16'h0000));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 32;
		stall_pct = 48;
		load_timers(16'd1, 16'd1, 16'd1, 16'd1);
		directed_items();
		run_phase(100, 32, 48);
		load_timers(16'($urandom_range(1, 4)), 16'($urandom_range(1, 40)),
		            16'($urandom_range(1, 40)), 16'($urandom_range(1, 20)));
		run_phase(100, 32, 48);
		load_timers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(100, 48, 32);
		load_timers(16'd2, 16'd0, 16'd3, 16'd0);
		run_phase(100, 48, 32);
		load_timers(16'($urandom_range(1, 4)), 16'($urandom_range(1, 40)),
		            16'($urandom_range(1, 40)), 16'($urandom_range(1, 20)));
		run_phase(100, 0, 0);
		load_timers(16'd1, 16'hFFFF, 16'hFFFF, 16'd5);
		run_phase(100, 0, 0);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
